### rtl/asn1te_pkg.sv
package asn1te_pkg;

	// storage and widths
	localparam int unsigned STORE_DEPTH = 15;
	localparam int unsigned STORE_AW    = 4;
	localparam int unsigned COUNT_W     = 5;
	localparam int unsigned COUNT_MAX   = 31;
	localparam int unsigned SECS_W      = 39;
	localparam int unsigned MAC_A_W     = 24;
	localparam int unsigned MAC_B_W     = 17;
	localparam int unsigned YEAR_W      = 14;
	localparam int unsigned FLD_W       = 7;
	localparam int unsigned TOD_W       = 17;
	localparam int unsigned DOY_W       = 9;

	// value lengths
	localparam int unsigned LEN_UTC = 13;
	localparam int unsigned LEN_GEN = 15;

	// ASCII
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_Z    = 8'h5A;

	// arithmetic constants
	localparam logic [MAC_B_W-1:0] SEC_PER_DAY  = 17'd86400;
	localparam logic [MAC_B_W-1:0] SEC_PER_MIN  = 17'd60;
	localparam logic [MAC_B_W-1:0] DAYS_PER_YR  = 17'd365;
	localparam logic [MAC_B_W-1:0] RECIP_25     = 17'd2622;   // ceil(2^16 / 25)
	localparam int unsigned        ERA_BIAS_YRS = 400;
	// 719468 epoch shift plus one era (146097 days) for the year bias
	localparam int unsigned        DAY_OFFSET   = 865565;
	localparam int unsigned        UTC_PIVOT    = 50;
	localparam int unsigned        CENT_20      = 2000;
	localparam int unsigned        CENT_19      = 1900;

	typedef enum logic [1:0] {
		KIND_UTC = 2'd0,
		KIND_GEN = 2'd1
	} kind_t;

	typedef enum logic [2:0] {
		FLD_YEAR = 3'd0,
		FLD_MON  = 3'd1,
		FLD_DAY  = 3'd2,
		FLD_HOUR = 3'd3,
		FLD_MIN  = 3'd4,
		FLD_SEC  = 3'd5
	} field_t;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_WALK   = 9'b000000010,
		ST_RANGE  = 9'b000000100,
		ST_MUL_H  = 9'b000001000,
		ST_MUL_M  = 9'b000010000,
		ST_MUL_Q  = 9'b000100000,
		ST_MUL_Y  = 9'b001000000,
		ST_MUL_D  = 9'b010000000,
		ST_FINISH = 9'b100000000
	} state_t;

	// Field owning a character; UTCTime is shifted by two so both kinds share a map.
	function automatic field_t field_of(input logic [STORE_AW-1:0] idx, input logic gen);
		logic [STORE_AW-1:0] pos;
		field_t f;
		pos = gen ? idx : STORE_AW'(idx + STORE_AW'(2));
		case (pos)
			4'd0, 4'd1, 4'd2, 4'd3: f = FLD_YEAR;
			4'd4, 4'd5:             f = FLD_MON;
			4'd6, 4'd7:             f = FLD_DAY;
			4'd8, 4'd9:             f = FLD_HOUR;
			4'd10, 4'd11:           f = FLD_MIN;
			default:                f = FLD_SEC;
		endcase
		return f;
	endfunction

	// (153 * mp + 2) / 5, day of March-based year at start of month mp
	function automatic logic [DOY_W-1:0] doy_base(input logic [3:0] mp);
		logic [DOY_W-1:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/asn1_time_to_epoch_seconds.sv
// ASN.1 UTCTime / GeneralizedTime to signed Unix seconds. Characters arrive one
// request per byte; while the block is idle every byte is taken in the cycle it
// shows up. On the last byte the block stalls its input and decodes: one walk step per
// stored character (13 or 15) to check digits and build the fields through a
// shared multiply-by-ten accumulator, a step for the range check and year
// fix, then five passes through a single 24x17 multiply-add unit (time of day,
// quotient for the century terms, day count, seconds), and a last step to load
// the result register. A bad digit, terminator or field range ends the decode
// after the range check; a wrong length or kind goes straight to the result step.
// The result waits in an output register, so a new value's bytes, its last byte
// included, are taken while an earlier result is still stalled; that value's
// decode then holds in its final step until the result register frees, adding
// those cycles to the input stall. bad_time marks a bad length, kind, terminator,
// digit or field range, and epoch_seconds is then zero. Day of month is only
// checked against 1..31.
module asn1_time_to_epoch_seconds (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [7:0]                            char_byte,
	input  logic [1:0]                            time_kind,
	input  logic                                  last_char,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [asn1te_pkg::SECS_W-1:0]  epoch_seconds,
	output logic                                  bad_time
);

	asn1te_pkg::state_t state_q;

	logic [asn1te_pkg::COUNT_W-1:0]  cnt_q;
	logic [7:0]                      store_q [asn1te_pkg::STORE_DEPTH];
	logic [asn1te_pkg::STORE_AW-1:0] idx_q;
	logic                            gen_q;
	logic                            bad_q;

	logic [asn1te_pkg::YEAR_W-1:0] year_q;
	logic [asn1te_pkg::FLD_W-1:0]  mon_q, day_q, hour_q, min_q, sec_q;

	logic [asn1te_pkg::YEAR_W-1:0] yb_q;   // year shifted for Jan/Feb, plus one era
	logic [asn1te_pkg::DOY_W-1:0]  doy_q;
	logic [asn1te_pkg::TOD_W-1:0]  tod_q;
	logic [asn1te_pkg::SECS_W-1:0] p_q;    // multiply-add result

	logic                                 out_valid_q;
	logic [asn1te_pkg::SECS_W-1:0]        out_secs_q;
	logic                                 out_bad_q;

	// input side
	logic                           in_acc;
	logic [asn1te_pkg::COUNT_W-1:0] cnt_nx;
	logic                           len_ok;

	assign in_stall = (state_q != asn1te_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign cnt_nx   = (cnt_q < asn1te_pkg::COUNT_W'(asn1te_pkg::COUNT_MAX)) ?
		asn1te_pkg::COUNT_W'(cnt_q + 1'b1) : cnt_q;
	assign len_ok   =
		(time_kind == asn1te_pkg::KIND_UTC &&
			cnt_nx == asn1te_pkg::COUNT_W'(asn1te_pkg::LEN_UTC)) ||
		(time_kind == asn1te_pkg::KIND_GEN &&
			cnt_nx == asn1te_pkg::COUNT_W'(asn1te_pkg::LEN_GEN));

	// character walk
	logic [7:0]                      rd_byte;
	logic [asn1te_pkg::STORE_AW-1:0] end_idx;
	logic                            is_end;
	logic                            is_digit;
	asn1te_pkg::field_t              fsel;
	logic [asn1te_pkg::YEAR_W-1:0]   acc_cur;
	logic [asn1te_pkg::YEAR_W-1:0]   acc_nxt;

	assign rd_byte  = store_q[idx_q];
	assign end_idx  = gen_q ? asn1te_pkg::STORE_AW'(asn1te_pkg::LEN_GEN - 1) :
		asn1te_pkg::STORE_AW'(asn1te_pkg::LEN_UTC - 1);
	assign is_end   = (idx_q == end_idx);
	assign is_digit = (rd_byte >= asn1te_pkg::CH_ZERO) && (rd_byte <= asn1te_pkg::CH_NINE);
	assign fsel     = asn1te_pkg::field_of(idx_q, gen_q);

	always_comb begin
		case (fsel)
			asn1te_pkg::FLD_YEAR: acc_cur = year_q;
			asn1te_pkg::FLD_MON:  acc_cur = asn1te_pkg::YEAR_W'(mon_q);
			asn1te_pkg::FLD_DAY:  acc_cur = asn1te_pkg::YEAR_W'(day_q);
			asn1te_pkg::FLD_HOUR: acc_cur = asn1te_pkg::YEAR_W'(hour_q);
			asn1te_pkg::FLD_MIN:  acc_cur = asn1te_pkg::YEAR_W'(min_q);
			default:              acc_cur = asn1te_pkg::YEAR_W'(sec_q);
		endcase
	end

	// acc * 10 + digit
	assign acc_nxt = asn1te_pkg::YEAR_W'((acc_cur << 3) + (acc_cur << 1) +
		asn1te_pkg::YEAR_W'(rd_byte[3:0]));

	// range check and year fix
	logic                          range_bad;
	logic [asn1te_pkg::YEAR_W-1:0] year_fix;
	logic [asn1te_pkg::YEAR_W-1:0] yb_nx;
	logic [3:0]                    mp;
	logic [asn1te_pkg::DOY_W-1:0]  doy_nx;

	assign range_bad = (mon_q < 7'd1) || (mon_q > 7'd12) || (day_q < 7'd1) ||
		(day_q > 7'd31) || (hour_q > 7'd23) || (min_q > 7'd59) || (sec_q > 7'd60);

	always_comb begin
		if (gen_q) begin
			year_fix = year_q;
		end else if (year_q < asn1te_pkg::YEAR_W'(asn1te_pkg::UTC_PIVOT)) begin
			year_fix = asn1te_pkg::YEAR_W'(year_q + asn1te_pkg::YEAR_W'(asn1te_pkg::CENT_20));
		end else begin
			year_fix = asn1te_pkg::YEAR_W'(year_q + asn1te_pkg::YEAR_W'(asn1te_pkg::CENT_19));
		end
	end

	// March-based year, biased by one era so the value stays non-negative
	assign yb_nx  = asn1te_pkg::YEAR_W'(year_fix + asn1te_pkg::YEAR_W'(asn1te_pkg::ERA_BIAS_YRS) -
		asn1te_pkg::YEAR_W'(mon_q <= 7'd2));
	assign mp     = (mon_q > 7'd2) ? 4'(mon_q - 7'd3) : 4'(mon_q + 7'd9);
	assign doy_nx = asn1te_pkg::DOY_W'(asn1te_pkg::doy_base(mp) +
		asn1te_pkg::DOY_W'(day_q) - 1'b1);

	// shared multiply-add: p = a * b + c, modulo 2^39
	logic signed [asn1te_pkg::MAC_A_W-1:0]             mac_a;
	logic [asn1te_pkg::MAC_B_W-1:0]                    mac_b;
	logic [asn1te_pkg::SECS_W-1:0]                     mac_c;
	logic signed [asn1te_pkg::MAC_A_W+asn1te_pkg::MAC_B_W:0] mac_prod;
	logic [asn1te_pkg::SECS_W-1:0]                     mac_out;

	// century terms from q = Y/4: Y/100 = q/25, Y/400 = (q/25)/4
	logic [11:0]                   q_yr;
	logic [6:0]                    q25;
	logic [asn1te_pkg::SECS_W-1:0] day_add;

	assign q_yr    = yb_q[asn1te_pkg::YEAR_W-1:2];
	assign q25     = p_q[22:16];
	assign day_add = asn1te_pkg::SECS_W'(q_yr) - asn1te_pkg::SECS_W'(q25) +
		asn1te_pkg::SECS_W'(q25[6:2]) + asn1te_pkg::SECS_W'(doy_q) -
		asn1te_pkg::SECS_W'(asn1te_pkg::DAY_OFFSET);

	always_comb begin
		case (state_q)
			asn1te_pkg::ST_MUL_H: begin
				mac_a = asn1te_pkg::MAC_A_W'(hour_q);
				mac_b = asn1te_pkg::SEC_PER_MIN;
				mac_c = asn1te_pkg::SECS_W'(min_q);
			end
			asn1te_pkg::ST_MUL_M: begin
				mac_a = p_q[asn1te_pkg::MAC_A_W-1:0];
				mac_b = asn1te_pkg::SEC_PER_MIN;
				mac_c = asn1te_pkg::SECS_W'(sec_q);
			end
			asn1te_pkg::ST_MUL_Q: begin
				mac_a = asn1te_pkg::MAC_A_W'(q_yr);
				mac_b = asn1te_pkg::RECIP_25;
				mac_c = '0;
			end
			asn1te_pkg::ST_MUL_Y: begin
				mac_a = asn1te_pkg::MAC_A_W'(yb_q);
				mac_b = asn1te_pkg::DAYS_PER_YR;
				mac_c = day_add;
			end
			asn1te_pkg::ST_MUL_D: begin
				mac_a = p_q[asn1te_pkg::MAC_A_W-1:0];
				mac_b = asn1te_pkg::SEC_PER_DAY;
				mac_c = asn1te_pkg::SECS_W'(tod_q);
			end
			default: begin
				mac_a = '0;
				mac_b = '0;
				mac_c = '0;
			end
		endcase
	end

	assign mac_prod = mac_a * $signed({1'b0, mac_b});
	assign mac_out  = asn1te_pkg::SECS_W'(mac_prod[asn1te_pkg::SECS_W-1:0] + mac_c);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= asn1te_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the final decode step reloads the result register itself
			if (out_valid_q && !out_stall && state_q != asn1te_pkg::ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				asn1te_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (last_char) begin
							cnt_q   <= '0;
							state_q <= len_ok ? asn1te_pkg::ST_WALK : asn1te_pkg::ST_FINISH;
						end else begin
							cnt_q <= cnt_nx;
						end
					end
				end
				asn1te_pkg::ST_WALK: begin
					if (is_end) begin
						state_q <= asn1te_pkg::ST_RANGE;
					end
				end
				asn1te_pkg::ST_RANGE: begin
					state_q <= (bad_q || range_bad) ? asn1te_pkg::ST_FINISH :
						asn1te_pkg::ST_MUL_H;
				end
				asn1te_pkg::ST_MUL_H: state_q <= asn1te_pkg::ST_MUL_M;
				asn1te_pkg::ST_MUL_M: state_q <= asn1te_pkg::ST_MUL_Q;
				asn1te_pkg::ST_MUL_Q: state_q <= asn1te_pkg::ST_MUL_Y;
				asn1te_pkg::ST_MUL_Y: state_q <= asn1te_pkg::ST_MUL_D;
				asn1te_pkg::ST_MUL_D: state_q <= asn1te_pkg::ST_FINISH;
				asn1te_pkg::ST_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= asn1te_pkg::ST_IDLE;
					end
				end
				default: state_q <= asn1te_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc && cnt_q < asn1te_pkg::COUNT_W'(asn1te_pkg::STORE_DEPTH)) begin
			store_q[cnt_q[asn1te_pkg::STORE_AW-1:0]] <= char_byte;
		end
		case (state_q)
			asn1te_pkg::ST_IDLE: begin
				if (in_acc && last_char) begin
					bad_q  <= !len_ok;
					gen_q  <= (time_kind == asn1te_pkg::KIND_GEN);
					idx_q  <= '0;
					year_q <= '0;
					mon_q  <= '0;
					day_q  <= '0;
					hour_q <= '0;
					min_q  <= '0;
					sec_q  <= '0;
				end
			end
			asn1te_pkg::ST_WALK: begin
				if (is_end) begin
					if (rd_byte != asn1te_pkg::CH_Z) begin
						bad_q <= 1'b1;
					end
				end else begin
					if (!is_digit) begin
						bad_q <= 1'b1;
					end
					idx_q <= asn1te_pkg::STORE_AW'(idx_q + 1'b1);
					case (fsel)
						asn1te_pkg::FLD_YEAR: year_q <= acc_nxt;
						asn1te_pkg::FLD_MON:  mon_q  <= acc_nxt[asn1te_pkg::FLD_W-1:0];
						asn1te_pkg::FLD_DAY:  day_q  <= acc_nxt[asn1te_pkg::FLD_W-1:0];
						asn1te_pkg::FLD_HOUR: hour_q <= acc_nxt[asn1te_pkg::FLD_W-1:0];
						asn1te_pkg::FLD_MIN:  min_q  <= acc_nxt[asn1te_pkg::FLD_W-1:0];
						default:              sec_q  <= acc_nxt[asn1te_pkg::FLD_W-1:0];
					endcase
				end
			end
			asn1te_pkg::ST_RANGE: begin
				if (range_bad) begin
					bad_q <= 1'b1;
				end
				yb_q  <= yb_nx;
				doy_q <= doy_nx;
			end
			asn1te_pkg::ST_MUL_H, asn1te_pkg::ST_MUL_M, asn1te_pkg::ST_MUL_Y,
			asn1te_pkg::ST_MUL_D: begin
				p_q <= mac_out;
			end
			asn1te_pkg::ST_MUL_Q: begin
				tod_q <= p_q[asn1te_pkg::TOD_W-1:0];
				p_q   <= mac_out;
			end
			asn1te_pkg::ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_secs_q <= bad_q ? '0 : p_q;
					out_bad_q  <= bad_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign epoch_seconds = $signed(out_secs_q);
	assign bad_time      = out_bad_q;

	// a new result is loaded only from the final decode step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == asn1te_pkg::ST_FINISH))
		else $error("result appeared outside the final decode step");

	// an error result always carries zero seconds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_time |-> epoch_seconds == '0)
		else $error("error result with nonzero seconds");

	// the byte count restarts as soon as a value ends
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != asn1te_pkg::ST_IDLE |-> cnt_q == '0)
		else $error("byte count not cleared during decode");

	// the character walk never runs past the terminator
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == asn1te_pkg::ST_WALK |-> idx_q <= end_idx)
		else $error("character walk past end of value");

endmodule

### verif/asn1_time_to_epoch_seconds_chk.sv
`timescale 1ns / 1ps

module asn1_time_to_epoch_seconds_chk (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic [7:0]                            char_byte,
	input  logic [1:0]                            time_kind,
	input  logic                                  last_char,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [asn1te_pkg::SECS_W-1:0]  epoch_seconds,
	input  logic                                  bad_time,
	output int                                    fail_count,
	output int                                    awaited_count,
	output int                                    result_total,
	output int                                    bad_total
);

	typedef struct packed {
		logic signed [asn1te_pkg::SECS_W-1:0] secs;
		logic                                 bad;
	} epoch_result_t;

	logic [7:0]                     char_store [asn1te_pkg::STORE_DEPTH];
	logic [asn1te_pkg::COUNT_W-1:0] seen_count;
	epoch_result_t                  awaited_epochs [$];
	int                             errs;
	int                             n_results;
	int                             n_bad;

	function automatic longint digit_pair(input int unsigned pos);
		return (longint'(char_store[pos]) - longint'(asn1te_pkg::CH_ZERO)) * 10
			+ (longint'(char_store[pos + 1]) - longint'(asn1te_pkg::CH_ZERO));
	endfunction

	// proleptic Gregorian days since 1970-01-01
	function automatic longint civil_day_count(input longint y, input longint m,
			input longint d);
		longint era, yoe, mp, doy, doe;
		if (m <= 2) begin
			y = y - 1;
		end
		era = ((y >= 0) ? y : y - 399) / 400;
		yoe = y - era * 400;
		mp  = (m > 2) ? (m - 3) : (m + 9);
		doy = (153 * mp + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	function automatic epoch_result_t decode_time_value(input logic [1:0] kind,
			input int unsigned len);
		epoch_result_t r;
		longint        year, mo, dy, hr, mn, sc, total;
		int unsigned   p;
		r.bad  = 1'b1;
		r.secs = '0;
		if (kind == asn1te_pkg::KIND_UTC) begin
			if (len != asn1te_pkg::LEN_UTC) return r;
		end else if (kind == asn1te_pkg::KIND_GEN) begin
			if (len != asn1te_pkg::LEN_GEN) return r;
		end else begin
			return r;
		end
		if (char_store[len - 1] != asn1te_pkg::CH_Z) return r;
		for (int unsigned i = 0; i + 1 < len; i++) begin
			if (char_store[i] < asn1te_pkg::CH_ZERO || char_store[i] > asn1te_pkg::CH_NINE)
				return r;
		end
		if (kind == asn1te_pkg::KIND_UTC) begin
			year = digit_pair(0);
			year = (year < asn1te_pkg::UTC_PIVOT) ? asn1te_pkg::CENT_20 + year :
				asn1te_pkg::CENT_19 + year;
			p    = 2;
		end else begin
			year = digit_pair(0) * 100 + digit_pair(2);
			p    = 4;
		end
		mo = digit_pair(p);
		dy = digit_pair(p + 2);
		hr = digit_pair(p + 4);
		mn = digit_pair(p + 6);
		sc = digit_pair(p + 8);
		if (mo < 1 || mo > 12 || dy < 1 || dy > 31 || hr > 23 || mn > 59 || sc > 60) return r;
		total  = civil_day_count(year, mo, dy) * 86400 + hr * 3600 + mn * 60 + sc;
		r.secs = total[asn1te_pkg::SECS_W-1:0];
		r.bad  = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		epoch_result_t exp_r;
		if (!arst_n) begin
			seen_count = '0;
			awaited_epochs.delete();
			errs      = 0;
			n_results = 0;
			n_bad     = 0;
		end else begin
			// results first, so a request taken at this same edge cannot pair with them
			if (out_valid && !out_stall) begin
				if (awaited_epochs.size() == 0) begin
					$error("result with nothing awaited: epoch_seconds %0d bad_time %0b",
						epoch_seconds, bad_time);
					errs++;
				end else begin
					exp_r = awaited_epochs.pop_front();
					n_results++;
					if (exp_r.bad) n_bad++;
					if (epoch_seconds !== exp_r.secs) begin
						$error("epoch_seconds: expected %0d, actual %0d",
							exp_r.secs, epoch_seconds);
						errs++;
					end
					if (bad_time !== exp_r.bad) begin
						$error("bad_time: expected %0b, actual %0b", exp_r.bad, bad_time);
						errs++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (seen_count < asn1te_pkg::STORE_DEPTH) char_store[seen_count] = char_byte;
				if (seen_count < asn1te_pkg::COUNT_MAX) seen_count = seen_count + 1'b1;
				if (last_char) begin
					awaited_epochs.push_back(decode_time_value(time_kind, seen_count));
					seen_count = '0;
				end
			end
		end
		fail_count    <= errs;
		awaited_count <= awaited_epochs.size();
		result_total  <= n_results;
		bad_total     <= n_bad;
	end

endmodule

### verif/asn1_time_to_epoch_seconds_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the ASN.1 time decoder. All prediction and
// comparison lives in the checker instance; this module only feeds
// characters, throttles the result side and decides pass or fail.
module asn1_time_to_epoch_seconds_tb;

	typedef logic [7:0] char_q_t [$];

	// time_kind codes past the two known tags; both must be refused
	localparam logic [1:0] KIND_OTHER = 2'd2;
	localparam logic [1:0] KIND_RSVD  = 2'd3;

	localparam int RAND_CHARS = 550;
	localparam int DRAIN_CYCLES = 60;   // well past the longest decode

	logic                                 clk;
	logic                                 arst_n    = 1'b0;
	logic                                 in_valid  = 1'b0;
	logic                                 in_stall;
	logic [7:0]                           char_byte = '0;
	logic [1:0]                           time_kind = '0;
	logic                                 last_char = 1'b0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic signed [asn1te_pkg::SECS_W-1:0] epoch_seconds;
	logic                                 bad_time;

	int fail_count, awaited_count, result_total, bad_total;

	// idling knobs, percent per cycle
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;

	int chars_sent  = 0;
	int values_sent = 0;

	asn1_time_to_epoch_seconds dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_byte     (char_byte),
		.time_kind     (time_kind),
		.last_char     (last_char),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.epoch_seconds (epoch_seconds),
		.bad_time      (bad_time)
	);

	asn1_time_to_epoch_seconds_chk epoch_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_byte     (char_byte),
		.time_kind     (time_kind),
		.last_char     (last_char),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.epoch_seconds (epoch_seconds),
		.bad_time      (bad_time),
		.fail_count    (fail_count),
		.awaited_count (awaited_count),
		.result_total  (result_total),
		.bad_total     (bad_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stall, redrawn every cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	// hard stop
	initial begin
		#3_000_000;
		$display("asn1_time_to_epoch_seconds_tb: done, errors");
		$finish;
	end

	// One character request. An idle gap drops valid first; with no gap, valid
	// stays high and only the payload moves, so valid sees one update per edge.
	task automatic send_char(input logic [7:0] ch, input logic [1:0] kind, input logic last);
		if ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_byte <= ch;
		time_kind <= kind;
		last_char <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		chars_sent++;
	endtask

	// Whole value; kind is random on all but the last character since only
	// the last one's kind is meant to count.
	task automatic send_value(input char_q_t v, input logic [1:0] kind);
		int n;
		n = v.size();
		for (int i = 0; i < n; i++) begin
			if (i == n - 1) send_char(v[i], kind, 1'b1);
			else send_char(v[i], 2'($urandom_range(3)), 1'b0);
		end
		values_sent++;
	endtask

	function automatic char_q_t text_chars(input string s);
		char_q_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	task automatic send_text(input string s, input logic [1:0] kind);
		send_value(text_chars(s), kind);
	endtask

	// mostly random in range, sometimes pinned to an end
	function automatic int pick(input int lo, input int hi);
		int r;
		r = $urandom_range(7);
		if (r == 0) return lo;
		if (r == 1) return hi;
		return $urandom_range(hi, lo);
	endfunction

	// wild = fields drawn over the full two-digit span, so range errors show up
	function automatic string make_time_text(input bit gen, input bit wild);
		int yr, mo, dy, hr, mn, sc;
		yr = gen ? pick(0, 9999) : pick(0, 99);
		if (wild) begin
			mo = pick(0, 99);
			dy = pick(0, 99);
			hr = pick(0, 99);
			mn = pick(0, 99);
			sc = pick(0, 99);
		end else begin
			mo = pick(1, 12);
			dy = pick(1, 31);
			hr = pick(0, 23);
			mn = pick(0, 59);
			sc = pick(0, 60);
		end
		if (gen) return $sformatf("%04d%02d%02d%02d%02d%02dZ", yr, mo, dy, hr, mn, sc);
		return $sformatf("%02d%02d%02d%02d%02d%02dZ", yr, mo, dy, hr, mn, sc);
	endfunction

	initial begin
		char_q_t    v;
		int         rand_chars;
		int         r;
		int         pos;
		bit         gen;
		logic [1:0] kind;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed: no idling on either side ----
		send_text("700101000000Z", asn1te_pkg::KIND_UTC);      // epoch itself
		send_text("491231235959Z", asn1te_pkg::KIND_UTC);      // top of the 20xx window
		send_text("500101000000Z", asn1te_pkg::KIND_UTC);      // bottom of the 19xx window
		send_text("00000101000000Z", asn1te_pkg::KIND_GEN);    // lowest representable time
		send_text("99991231235960Z", asn1te_pkg::KIND_GEN);    // highest, with a leap second
		send_text("19691231235959Z", asn1te_pkg::KIND_GEN);    // one second before the epoch
		send_text("20230231000000Z", asn1te_pkg::KIND_GEN);    // Feb 31 passes
		send_text("991301000000Z", asn1te_pkg::KIND_UTC);      // month too large
		send_text("990100000000Z", asn1te_pkg::KIND_UTC);      // day zero
		send_text("991231240000Z", asn1te_pkg::KIND_UTC);      // hour 24
		send_text("991231236000Z", asn1te_pkg::KIND_UTC);      // minute 60
		send_text("991231235961Z", asn1te_pkg::KIND_UTC);      // second 61
		send_text("9912312359590", asn1te_pkg::KIND_UTC);      // terminator missing
		send_text("99:231235959Z", asn1te_pkg::KIND_UTC);      // just above '9'
		send_text("99/231235959Z", asn1te_pkg::KIND_UTC);      // just below '0'
		send_text("991231235959Z", asn1te_pkg::KIND_GEN);      // UTCTime length, wrong kind
		send_text("20001231235959Z", asn1te_pkg::KIND_UTC);    // and the other way around
		send_text("Z", KIND_OTHER);                            // unknown tag
		send_text("991231235959Z", KIND_RSVD);                 // good text, reserved tag
		v = {8'h00, 8'hFF};
		send_value(v, asn1te_pkg::KIND_UTC);                   // extreme character codes
		v = text_chars("2000123123595");
		v.push_back(8'h5A);
		v.push_back(asn1te_pkg::CH_Z);
		send_value(v, asn1te_pkg::KIND_GEN);                   // fills the store exactly, a Z in a digit slot
		v.delete();
		repeat (35) v.push_back(asn1te_pkg::CH_ZERO);
		send_value(v, asn1te_pkg::KIND_GEN);                   // count saturates

		// ---- random: four idling phases by share of characters sent ----
		rand_chars = 0;
		while (rand_chars < RAND_CHARS) begin
			case ((rand_chars * 4) / RAND_CHARS)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 78; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 78; end
				default: begin src_idle_pct = 38; sink_stall_pct = 38; end
			endcase
			gen  = 1'($urandom_range(1));
			kind = gen ? asn1te_pkg::KIND_GEN : asn1te_pkg::KIND_UTC;
			v    = text_chars(make_time_text(gen, 1'b0));
			r    = $urandom_range(99);
			if (r < 70) begin
				// well-formed, random content
			end else if (r < 80) begin
				pos    = $urandom_range(v.size() - 1);
				v[pos] = 8'($urandom_range(255));
			end else if (r < 85) begin
				v = text_chars(make_time_text(gen, 1'b1));
			end else if (r < 90) begin
				case ($urandom_range(2))
					0: kind = gen ? asn1te_pkg::KIND_UTC : asn1te_pkg::KIND_GEN;
					1: kind = KIND_OTHER;
					default: kind = KIND_RSVD;
				endcase
			end else if (r < 95) begin
				case ($urandom_range(2))
					0: v.delete($urandom_range(v.size() - 1));
					1: v.insert($urandom_range(v.size()),
						8'($urandom_range(asn1te_pkg::CH_NINE, asn1te_pkg::CH_ZERO)));
					default: v[v.size() - 1] = 8'($urandom_range(255));
				endcase
			end else begin
				// raw noise, lengths past the counter's ceiling included
				v.delete();
				repeat ($urandom_range(40, 1)) v.push_back(8'($urandom_range(255)));
				kind = 2'($urandom_range(3));
			end
			send_value(v, kind);
			rand_chars += v.size();
		end
		in_valid <= 1'b0;
		@(posedge clk);

		// drain, then let the block settle
		while (awaited_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d characters in %0d values, %0d results checked, %0d flagged bad",
			chars_sent, values_sent, result_total, bad_total);
		if (fail_count == 0) begin
			$display("asn1_time_to_epoch_seconds_tb: done, clean");
		end else begin
			$display("asn1_time_to_epoch_seconds_tb: done, errors");
		end
		$finish;
	end

endmodule
